// File: rtl/cau_pkg.sv
// Shared types and constants for the complex arithmetic unit.
// No dependencies; the top level and the checker use it by scoped names.
package cau_pkg;

	// Operation codes carried in the command field
	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	// Default operand fraction width (Q8.8 operands, Q16.16 results)
	localparam int FRAC_BITS_DEF = 8;

	// Result word limits
	localparam logic [31:0] RES_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] RES_MIN = 32'h8000_0000;

	// Side data that rides along the divider stages
	typedef struct packed {
		cmd_t        cmd;
		logic [33:0] alt_re;   // add/sub/mul result before saturation
		logic [33:0] alt_im;
		logic [31:0] den;      // c*c + d*d
		logic        neg_re;   // sign of the real quotient
		logic        neg_im;   // sign of the imaginary quotient
	} side_t;

endpackage

// File: rtl/complex_arith_unit_top.sv
// Complex arithmetic unit: add, subtract, multiply, divide on Q8.8 pairs.
// Throughput: one word per cycle unless the output stalls.
// The divider is one restoring step per stage, 32 + 2*FRAC_BITS stages per lane,
// and every command flows through them.
// A one-word input skid buffer takes a word while the output word waits.
// Reset (arst_n low) clears all valid bits; payload registers are not reset.
module complex_arith_unit_top #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic signed [15:0] a_real,
	input  logic signed [15:0] a_imag,
	input  logic signed [15:0] b_real,
	input  logic signed [15:0] b_imag,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] res_real,
	output logic signed [31:0] res_imag,
	output logic               divide_by_zero,
	output logic               overflow
);

	localparam int SH = 2 * FRAC_BITS;
	localparam int NW = 32 + SH;   // dividend and quotient width

	// Pipeline advance: output register empty or being taken
	logic en;
	logic out_valid_q;
	assign en = !out_valid_q || !out_stall;

	// Input skid buffer
	logic        skid_v_q;
	logic [1:0]  skid_cmd_q;
	logic [15:0] skid_a_q, skid_b_q, skid_c_q, skid_d_q;
	logic        take;

	assign in_stall = skid_v_q;
	assign take     = in_valid && !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (en) begin
			skid_v_q <= 1'b0;
		end else if (take) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && take) begin
			skid_cmd_q <= command;
			skid_a_q   <= a_real;
			skid_b_q   <= a_imag;
			skid_c_q   <= b_real;
			skid_d_q   <= b_imag;
		end
	end

	// Stage 1: capture the operand word
	logic                v_s1;
	cau_pkg::cmd_t       cmd_s1;
	logic signed [15:0]  a_s1, b_s1, c_s1, d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= skid_v_q || in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (skid_v_q) begin
				cmd_s1 <= cau_pkg::cmd_t'(skid_cmd_q);
				a_s1   <= skid_a_q;
				b_s1   <= skid_b_q;
				c_s1   <= skid_c_q;
				d_s1   <= skid_d_q;
			end else begin
				cmd_s1 <= cau_pkg::cmd_t'(command);
				a_s1   <= a_real;
				b_s1   <= a_imag;
				c_s1   <= b_real;
				d_s1   <= b_imag;
			end
		end
	end

	// Stage 2: partial products and plain sums
	logic                v_s2;
	cau_pkg::cmd_t       cmd_s2;
	logic signed [31:0]  ac_s2, bd_s2, ad_s2, bc_s2, cc_s2, dd_s2;
	logic signed [16:0]  sre_s2, sim_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2 <= cmd_s1;
			ac_s2  <= a_s1 * c_s1;
			bd_s2  <= b_s1 * d_s1;
			ad_s2  <= a_s1 * d_s1;
			bc_s2  <= b_s1 * c_s1;
			cc_s2  <= c_s1 * c_s1;
			dd_s2  <= d_s1 * d_s1;
			if (cmd_s1 == cau_pkg::CMD_SUB) begin
				sre_s2 <= 17'(a_s1) - 17'(c_s1);
				sim_s2 <= 17'(b_s1) - 17'(d_s1);
			end else begin
				sre_s2 <= 17'(a_s1) + 17'(c_s1);
				sim_s2 <= 17'(b_s1) + 17'(d_s1);
			end
		end
	end

	// Stage 3: numerators, divisor and non-divide results
	logic                v_s3;
	cau_pkg::cmd_t       cmd_s3;
	logic signed [32:0]  nre_s3, nim_s3;
	logic [31:0]         den_s3;
	logic signed [33:0]  alt_re_s3, alt_im_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s3 <= cmd_s2;
			nre_s3 <= 33'(ac_s2) + 33'(bd_s2);
			nim_s3 <= 33'(bc_s2) - 33'(ad_s2);
			den_s3 <= 32'(cc_s2) + 32'(dd_s2);
			if (cmd_s2 == cau_pkg::CMD_MUL) begin
				alt_re_s3 <= 34'(ac_s2) - 34'(bd_s2);
				alt_im_s3 <= 34'(ad_s2) + 34'(bc_s2);
			end else begin
				alt_re_s3 <= 34'(sre_s2) <<< FRAC_BITS;
				alt_im_s3 <= 34'(sim_s2) <<< FRAC_BITS;
			end
		end
	end

	// Stage 4: magnitudes into the divider, side data packed
	logic              v_s4;
	logic [NW-1:0]     sh_re_s4, sh_im_s4;
	cau_pkg::side_t    side_s4;
	logic [32:0]       mre_d, mim_d;

	assign mre_d = nre_s3[32] ? 33'(-nre_s3) : 33'(nre_s3);
	assign mim_d = nim_s3[32] ? 33'(-nim_s3) : 33'(nim_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sh_re_s4       <= NW'(mre_d[31:0]) << SH;
			sh_im_s4       <= NW'(mim_d[31:0]) << SH;
			side_s4.cmd    <= cmd_s3;
			side_s4.alt_re <= alt_re_s3;
			side_s4.alt_im <= alt_im_s3;
			side_s4.den    <= den_s3;
			side_s4.neg_re <= nre_s3[32];
			side_s4.neg_im <= nim_s3[32];
		end
	end

	// Divider stages: entry 0 is stage 4, entry k is stage 4 + k
	logic              v_s5     [NW+1];
	logic [31:0]       rem_re_s5[NW+1];
	logic [31:0]       rem_im_s5[NW+1];
	logic [NW-1:0]     sh_re_s5 [NW+1];
	logic [NW-1:0]     sh_im_s5 [NW+1];
	cau_pkg::side_t    side_s5  [NW+1];

	assign v_s5[0]      = v_s4;
	assign rem_re_s5[0] = '0;
	assign rem_im_s5[0] = '0;
	assign sh_re_s5[0]  = sh_re_s4;
	assign sh_im_s5[0]  = sh_im_s4;
	assign side_s5[0]   = side_s4;

	for (genvar k = 0; k < NW; k++) begin : g_div
		logic [32:0] tre, tim;
		logic        qre, qim;

		// One restoring step per lane: shift in a dividend bit, try subtract
		assign tre = {rem_re_s5[k], sh_re_s5[k][NW-1]};
		assign tim = {rem_im_s5[k], sh_im_s5[k][NW-1]};
		assign qre = tre >= {1'b0, side_s5[k].den};
		assign qim = tim >= {1'b0, side_s5[k].den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s5[k+1] <= 1'b0;
			end else if (en) begin
				v_s5[k+1] <= v_s5[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_re_s5[k+1] <= qre ? 32'(tre - {1'b0, side_s5[k].den}) : tre[31:0];
				rem_im_s5[k+1] <= qim ? 32'(tim - {1'b0, side_s5[k].den}) : tim[31:0];
				sh_re_s5[k+1]  <= {sh_re_s5[k][NW-2:0], qre};
				sh_im_s5[k+1]  <= {sh_im_s5[k][NW-2:0], qim};
				side_s5[k+1]   <= side_s5[k];
			end
		end
	end

	// Final select and saturation
	cau_pkg::side_t  fs;
	logic [NW-1:0]   qre_f, qim_f;
	logic [31:0]     re_d, im_d;
	logic            ovre_d, ovim_d, dz_d;

	assign fs    = side_s5[NW];
	assign qre_f = sh_re_s5[NW];
	assign qim_f = sh_im_s5[NW];

	function automatic logic [32:0] sat_quot(input logic [NW-1:0] q, input logic neg);
		logic hi;
		logic [32:0] r;
		hi = |(q >> 32);
		if (!neg) begin
			if (hi || q[31]) r = {1'b1, cau_pkg::RES_MAX};
			else             r = {1'b0, q[31:0]};
		end else begin
			if (hi || (q[31] && (|q[30:0]))) r = {1'b1, cau_pkg::RES_MIN};
			else                             r = {1'b0, 32'(-q[31:0])};
		end
		return r;
	endfunction

	function automatic logic [32:0] sat_alt(input logic [33:0] v);
		logic [32:0] r;
		if (v[33:31] == 3'b000 || v[33:31] == 3'b111) r = {1'b0, v[31:0]};
		else if (v[33])                               r = {1'b1, cau_pkg::RES_MIN};
		else                                          r = {1'b1, cau_pkg::RES_MAX};
		return r;
	endfunction

	always_comb begin
		logic [32:0] sr, si;
		if (fs.cmd == cau_pkg::CMD_DIV) begin
			sr = sat_quot(qre_f, fs.neg_re);
			si = sat_quot(qim_f, fs.neg_im);
		end else begin
			sr = sat_alt(fs.alt_re);
			si = sat_alt(fs.alt_im);
		end
		dz_d = (fs.cmd == cau_pkg::CMD_DIV) && (fs.den == '0);
		if (dz_d) begin
			re_d   = '0;
			im_d   = '0;
			ovre_d = 1'b0;
			ovim_d = 1'b0;
		end else begin
			re_d   = sr[31:0];
			im_d   = si[31:0];
			ovre_d = sr[32];
			ovim_d = si[32];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s5[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_real       <= re_d;
			res_imag       <= im_d;
			divide_by_zero <= dz_d;
			overflow       <= ovre_d || ovim_d;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/cau_checker.sv
// Port-level checks for the complex arithmetic unit, bound to the top level.
// Depends on cau_pkg for the result limits.
module cau_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         command,
	input logic signed [15:0] a_real,
	input logic signed [15:0] a_imag,
	input logic signed [15:0] b_real,
	input logic signed [15:0] b_imag,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] res_real,
	input logic signed [31:0] res_imag,
	input logic               divide_by_zero,
	input logic               overflow
);

	// Hold a stalled output word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(res_real) && $stable(res_imag))
		else $error("stalled output word changed");

	// Zero divisor gives a zero word and no saturation
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> res_real == 0 && res_imag == 0 && !overflow)
		else $error("zero divisor word not cleared");

	// Saturation leaves a limit value in some part
	a_ovf_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |->
			res_real == cau_pkg::RES_MAX || res_real == cau_pkg::RES_MIN ||
			res_imag == cau_pkg::RES_MAX || res_imag == cau_pkg::RES_MIN)
		else $error("overflow flag without saturated part");

endmodule

bind complex_arith_unit_top cau_checker u_cau_checker (.*);

// File: test/tb_complex_arith_unit_top.sv
// Testbench for complex_arith_unit_top: directed and random complex operations
// checked against a built-in fixed-point predictor. Depends on rtl/cau_pkg.sv.
`timescale 1ns / 100ps

module tb_complex_arith_unit_top;

	localparam int FB        = cau_pkg::FRAC_BITS_DEF;
	localparam int LATENCY   = 2 * FB + 36;
	localparam int MAX_CYC   = 1000000;

	typedef struct packed {
		logic signed [31:0] re;
		logic signed [31:0] im;
		logic               dz;
		logic               ovf;
	} cplx_res_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         command;
	logic signed [15:0] a_real, a_imag, b_real, b_imag;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] res_real, res_imag;
	logic               divide_by_zero, overflow;

	cplx_res_t pending_results[$];
	int        fail_count;
	int        cycle_count;
	int        send_idle_pct;
	int        recv_stall_pct;
	int        hold_cycles;

	complex_arith_unit_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .a_real(a_real), .a_imag(a_imag),
		.b_real(b_real), .b_imag(b_imag),
		.out_valid(out_valid), .out_stall(out_stall),
		.res_real(res_real), .res_imag(res_imag),
		.divide_by_zero(divide_by_zero), .overflow(overflow)
	);

	// Clock: 8 ns period
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Saturate a wide value to 32 bits and note overflow
	function automatic logic signed [31:0] clamp32(input logic signed [63:0] v,
			inout logic ovf);
		if (v > 64'sd2147483647) begin
			ovf = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		if (v < -64'sd2147483648) begin
			ovf = 1'b1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// Compute the expected complex result for one operand word
	function automatic cplx_res_t complex_result(input cau_pkg::cmd_t op,
			input logic signed [15:0] ar, ai, br, bi);
		logic signed [63:0] a, b, c, d, re, im, den;
		logic ovf;
		cplx_res_t r;
		a = ar; b = ai; c = br; d = bi;
		re = 0; im = 0; ovf = 1'b0;
		r.dz = 1'b0;
		case (op)
			cau_pkg::CMD_ADD: begin
				re = (a + c) <<< FB;
				im = (b + d) <<< FB;
			end
			cau_pkg::CMD_SUB: begin
				re = (a - c) <<< FB;
				im = (b - d) <<< FB;
			end
			cau_pkg::CMD_MUL: begin
				re = a * c - b * d;
				im = a * d + b * c;
			end
			default: begin
				den = c * c + d * d;
				if (den == 0) begin
					r.dz = 1'b1;
				end else begin
					re = ((a * c + b * d) <<< (2 * FB)) / den;
					im = ((b * c - a * d) <<< (2 * FB)) / den;
				end
			end
		endcase
		r.re = clamp32(re, ovf);
		r.im = clamp32(im, ovf);
		r.ovf = ovf;
		return r;
	endfunction

	// Offer one word, hold it until accepted, and log its expected result
	task automatic send_word(input cau_pkg::cmd_t op,
			input logic signed [15:0] ar, ai, br, bi);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= op;
		a_real   <= ar;
		a_imag   <= ai;
		b_real   <= br;
		b_imag   <= bi;
		pending_results.push_back(complex_result(op, ar, ai, br, bi));
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Random operand: full range half the time, else an edge or near-zero value
	function automatic logic signed [15:0] rand_part();
		case ($urandom_range(7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'($urandom_range(7)) - 16'd3;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_random(input int n);
		cau_pkg::cmd_t op;
		logic signed [15:0] br, bi;
		for (int k = 0; k < n; k++) begin
			op = cau_pkg::cmd_t'($urandom_range(3));
			br = rand_part();
			bi = ($urandom_range(9) == 0) ? 16'sh0000 : rand_part();
			send_word(op, rand_part(), rand_part(), br, bi);
		end
	endtask

	// Drop the input and wait for every expected word
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic test_directed();
		send_idle_pct = 0; recv_stall_pct = 0;
		send_word(cau_pkg::CMD_ADD, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_word(cau_pkg::CMD_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_word(cau_pkg::CMD_SUB, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
		send_word(cau_pkg::CMD_SUB, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
		send_word(cau_pkg::CMD_MUL, 16'sh0100, 16'sh0200, 16'sh0300, 16'sh0400);
		// Multiply near the limits; only the all-minimum word overflows, in the imaginary part
		send_word(cau_pkg::CMD_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF);
		send_word(cau_pkg::CMD_MUL, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
		send_word(cau_pkg::CMD_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_word(cau_pkg::CMD_MUL, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		// Divide: plain, truncation toward zero, saturation, zero divisor
		send_word(cau_pkg::CMD_DIV, 16'sh0400, 16'sh0200, 16'sh0100, 16'sh0000);
		send_word(cau_pkg::CMD_DIV, 16'sh0001, 16'sh0000, 16'sh0003, 16'sh0000);
		send_word(cau_pkg::CMD_DIV, -16'sh0001, 16'sh0000, 16'sh0003, 16'sh0000);
		send_word(cau_pkg::CMD_DIV, 16'sh7FFF, 16'sh7FFF, 16'sh0001, 16'sh0000);
		send_word(cau_pkg::CMD_DIV, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0001);
		send_word(cau_pkg::CMD_DIV, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_word(cau_pkg::CMD_DIV, 16'sh1234, 16'sh5678, 16'sh0000, 16'sh0000);
		send_word(cau_pkg::CMD_DIV, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000);
		send_word(cau_pkg::CMD_DIV, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
		wait_drained();
	endtask

	task automatic test_random_phases();
		send_idle_pct = 0;  recv_stall_pct = 0;  send_random(400);
		send_idle_pct = 84; recv_stall_pct = 0;  send_random(300);
		send_idle_pct = 0;  recv_stall_pct = 84; send_random(300);
		send_idle_pct = 26; recv_stall_pct = 26; send_random(400);
		send_idle_pct = 0;  recv_stall_pct = 0;  send_random(250);
	endtask

	// Hold the output for a long stretch while words keep being offered
	task automatic test_backpressure();
		send_idle_pct = 0; recv_stall_pct = 0;
		hold_cycles = 300;
		send_random(100);
	endtask

	// Receiver stall: random, or a counted hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Check each accepted result word against the oldest expectation
	always @(posedge clk) begin
		cplx_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (res_real !== want.re) begin
					$error("res_real: expected %0d, got %0d", want.re, res_real);
					fail_count++;
				end
				if (res_imag !== want.im) begin
					$error("res_imag: expected %0d, got %0d", want.im, res_imag);
					fail_count++;
				end
				if (divide_by_zero !== want.dz) begin
					$error("divide_by_zero: expected %0b, got %0b", want.dz,
						divide_by_zero);
					fail_count++;
				end
				if (overflow !== want.ovf) begin
					$error("overflow: expected %0b, got %0b", want.ovf, overflow);
					fail_count++;
				end
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYC) begin
			$display("** complex_arith_unit_top: FAILED **");
			$finish;
		end
	end

	initial begin
		fail_count = 0; cycle_count = 0; hold_cycles = 0;
		send_idle_pct = 0; recv_stall_pct = 0;
		arst_n = 1'b0; in_valid = 1'b0; command = '0;
		a_real = '0; a_imag = '0; b_real = '0; b_imag = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random_phases();
		wait_drained();
		if (fail_count == 0)
			$display("** complex_arith_unit_top: PASSED **");
		else
			$display("** complex_arith_unit_top: FAILED **");
		$finish;
	end

endmodule
